/* hw/rtl/spa_pkg.sv */
// Package for the slot pool allocator: shared widths, codes and FSM state type.
// No dependencies; imported by slot_pool_allocator_unit.
package spa_pkg;

  // Default pool depth; the design supports MAX_SLOTS from 1 to 16
  localparam int unsigned MAX_SLOTS_DEF = 16;

  // Fixed field widths of the request and response channels
  localparam int unsigned POOL_W      = 5;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_IDLE    = 2'd1,
    STAT_BUSY_EMPTY = 2'd2,
    STAT_BAD_SLOT   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_UNLINK,
    ST_LINK,
    ST_SPLICE
  } state_e;

endpackage

/* hw/rtl/slot_pool_allocator_unit.sv */
// Slot pool allocator top level: idle/busy doubly linked rings in link RAMs.
// Depends on spa_pkg and spa_ram.
//
//  channel   | dir | handshake                  | payload (low bit first)
//  ----------+-----+----------------------------+-----------------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready| operation[0], slot[4:1]
//  m_axis    | out | m_axis_tvalid/m_axis_tready| status[1:0], granted_slot[5:2],
//            |     |                            | idle_count[10:6], busy_count[15:11]
//  cfg       | in  | cfg_we_i (no wait)         | pool_size[4:0]
//
// A rejected request (no idle slot, busy ring empty, bad slot) answers at its accept edge.
// An acquire or release reads the slot's links, then does the unlink with a read of the
// target head's prev link, writes the slot's own links, and splices it in unless the
// target ring was empty, all bounded by the single read port of each link RAM.
// After reset and after each pool_size write a clearing pass rewrites all MAX_SLOTS
// link RAM entries, one entry a cycle; no request is accepted during it.
// A request is taken only while the output register is empty or being drained.
module slot_pool_allocator_unit
  import spa_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [POOL_W-1:0]      cfg_wdata_i,
  // request stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // operation, slot
  // response stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // status, granted_slot, idle_count, busy_count
);

  localparam int unsigned IdxW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_SLOTS + 1);
  localparam logic [POOL_W-1:0] PoolMax = POOL_W'(MAX_SLOTS);
  localparam logic [IdxW-1:0]   LastIdx = IdxW'(MAX_SLOTS - 1);

  // ---------------------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------------------
  state_e                 state_q, state_d;
  logic [POOL_W-1:0]      pool_q;
  logic [IdxW-1:0]        clr_q;
  logic [IdxW-1:0]        idle_head_q, busy_head_q;
  logic                   idle_empty_q, busy_empty_q;
  logic [CntW-1:0]        idle_total_q, busy_total_q;
  logic [MAX_SLOTS-1:0]   busy_mark_q;

  // operation in flight
  logic                   acq_q;
  logic [IdxW-1:0]        slot_q;
  logic [IdxW-1:0]        tgt_q;
  logic                   tgt_empty_q;
  logic [IdxW-1:0]        p2_q;

  // output register
  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  // link RAM ports
  logic            nxt_we, prv_we;
  logic [IdxW-1:0] nxt_waddr, prv_waddr, nxt_wdata, prv_wdata;
  logic [IdxW-1:0] nxt_raddr, prv_raddr, nxt_rdata, prv_rdata;

  spa_ram #(.WIDTH(IdxW), .DEPTH(MAX_SLOTS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .raddr_i (nxt_raddr),
    .rdata_o (nxt_rdata)
  );

  spa_ram #(.WIDTH(IdxW), .DEPTH(MAX_SLOTS)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_waddr),
    .wdata_i (prv_wdata),
    .raddr_i (prv_raddr),
    .rdata_o (prv_rdata)
  );

  // ---------------------------------------------------------------------------------------
  // Request decode and checks
  // ---------------------------------------------------------------------------------------
  op_e               in_op;
  logic [SLOT_W-1:0] in_slot;
  logic [IdxW-1:0]   req_idx;
  logic              in_range, req_busy, in_fire, req_err, start;
  status_e           err_status;
  logic [IdxW-1:0]   src_sel, tgt_sel;
  logic              tgt_empty_sel;

  assign in_op    = op_e'(s_axis_tdata[0]);
  assign in_slot  = s_axis_tdata[SLOT_W:1];
  assign req_idx  = IdxW'(in_slot);
  assign in_range = POOL_W'(in_slot) < pool_q;
  assign req_busy = in_range ? busy_mark_q[req_idx] : 1'b0;
  assign s_axis_tready = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready) && !cfg_we_i;
  assign in_fire  = s_axis_tvalid && s_axis_tready && !cfg_we_i;

  always_comb begin
    req_err    = 1'b0;
    err_status = STAT_OK;
    if (in_op == OP_ACQUIRE) begin
      if (idle_empty_q) begin
        req_err    = 1'b1;
        err_status = STAT_NO_IDLE;
      end
    end else if (busy_empty_q) begin
      req_err    = 1'b1;
      err_status = STAT_BUSY_EMPTY;
    end else if (!req_busy) begin
      req_err    = 1'b1;
      err_status = STAT_BAD_SLOT;
    end
  end

  assign start         = in_fire && !req_err;
  assign src_sel       = (in_op == OP_ACQUIRE) ? idle_head_q : req_idx;
  assign tgt_sel       = (in_op == OP_ACQUIRE) ? busy_head_q : idle_head_q;
  assign tgt_empty_sel = (in_op == OP_ACQUIRE) ? busy_empty_q : idle_empty_q;

  // unlink view of the slot's own links (valid in ST_UNLINK)
  logic unlink_alone;
  assign unlink_alone = (nxt_rdata == slot_q);

  // clearing pass values for entry clr_q
  logic [POOL_W-1:0] clr_w, clr_nxt, clr_prv;
  always_comb begin
    clr_w = POOL_W'(clr_q);
    if (clr_w < pool_q) begin
      clr_nxt = (clr_w + 1'b1 == pool_q) ? '0 : clr_w + 1'b1;
      clr_prv = (clr_w == '0) ? pool_q - 1'b1 : clr_w - 1'b1;
    end else begin
      clr_nxt = clr_w;
      clr_prv = clr_w;
    end
  end

  // clamped pool size of a configuration write
  logic [POOL_W-1:0] cfg_pool;
  always_comb begin
    cfg_pool = cfg_wdata_i;
    if (cfg_pool == '0) begin
      cfg_pool = POOL_W'(1);
    end
    if (cfg_pool > PoolMax) begin
      cfg_pool = PoolMax;
    end
  end

  // ---------------------------------------------------------------------------------------
  // FSM next state
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT:   if (clr_q == LastIdx) state_d = ST_IDLE;
      ST_IDLE:   if (start) state_d = ST_UNLINK;
      ST_UNLINK: state_d = ST_LINK;
      ST_LINK:   state_d = tgt_empty_q ? ST_IDLE : ST_SPLICE;
      ST_SPLICE: state_d = ST_IDLE;
      default:   state_d = ST_INIT;
    endcase
    if (cfg_we_i) begin
      state_d = ST_INIT;
    end
  end

  // ---------------------------------------------------------------------------------------
  // FSM outputs: link RAM accesses and completion
  // ---------------------------------------------------------------------------------------
  logic done;
  always_comb begin
    nxt_we    = 1'b0;
    prv_we    = 1'b0;
    nxt_waddr = slot_q;
    prv_waddr = slot_q;
    nxt_wdata = slot_q;
    prv_wdata = slot_q;
    nxt_raddr = src_sel;
    prv_raddr = src_sel;
    done      = 1'b0;
    case (state_q)
      ST_INIT: begin
        nxt_we    = 1'b1;
        prv_we    = 1'b1;
        nxt_waddr = clr_q;
        prv_waddr = clr_q;
        nxt_wdata = IdxW'(clr_nxt);
        prv_wdata = IdxW'(clr_prv);
      end
      ST_IDLE: begin
        // read the slot's own links
      end
      ST_UNLINK: begin
        // close the source ring around the slot, fetch prev link of the target head
        nxt_we    = !unlink_alone;
        prv_we    = !unlink_alone;
        nxt_waddr = prv_rdata;
        nxt_wdata = nxt_rdata;
        prv_waddr = nxt_rdata;
        prv_wdata = prv_rdata;
        prv_raddr = tgt_q;
      end
      ST_LINK: begin
        // slot's own links; a ring of one when the target was empty
        nxt_we    = 1'b1;
        prv_we    = 1'b1;
        nxt_wdata = tgt_empty_q ? slot_q : tgt_q;
        prv_wdata = tgt_empty_q ? slot_q : prv_rdata;
        done      = tgt_empty_q;
      end
      ST_SPLICE: begin
        nxt_we    = 1'b1;
        prv_we    = 1'b1;
        nxt_waddr = p2_q;
        prv_waddr = tgt_q;
        done      = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Ring heads, counts, busy marks and clearing counter
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      pool_q       <= PoolMax;
      clr_q        <= '0;
      idle_head_q  <= '0;
      busy_head_q  <= '0;
      idle_empty_q <= 1'b0;
      busy_empty_q <= 1'b1;
      idle_total_q <= CntW'(MAX_SLOTS);
      busy_total_q <= '0;
      busy_mark_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        pool_q       <= cfg_pool;
        clr_q        <= '0;
        idle_head_q  <= '0;
        busy_head_q  <= '0;
        idle_empty_q <= 1'b0;
        busy_empty_q <= 1'b1;
        idle_total_q <= CntW'(cfg_pool);
        busy_total_q <= '0;
        busy_mark_q  <= '0;
      end else if (state_q == ST_INIT) begin
        clr_q <= clr_q + 1'b1;
      end else if (state_q == ST_UNLINK) begin
        if (acq_q) begin
          idle_empty_q <= unlink_alone;
          if (!unlink_alone) idle_head_q <= nxt_rdata;
          busy_head_q  <= slot_q;
          busy_empty_q <= 1'b0;
          busy_mark_q[slot_q] <= 1'b1;
          if (idle_total_q != '0) idle_total_q <= idle_total_q - 1'b1;
          busy_total_q <= busy_total_q + 1'b1;
        end else begin
          busy_empty_q <= unlink_alone;
          if (!unlink_alone) busy_head_q <= nxt_rdata;
          idle_head_q  <= slot_q;
          idle_empty_q <= 1'b0;
          busy_mark_q[slot_q] <= 1'b0;
          idle_total_q <= idle_total_q + 1'b1;
          if (busy_total_q != '0) busy_total_q <= busy_total_q - 1'b1;
        end
      end
    end
  end

  // operation registers
  always_ff @(posedge clk_i) begin
    if (start) begin
      acq_q       <= (in_op == OP_ACQUIRE);
      slot_q      <= src_sel;
      tgt_q       <= tgt_sel;
      tgt_empty_q <= tgt_empty_sel;
    end
    if (state_q == ST_LINK) begin
      p2_q <= prv_rdata;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Response register
  // ---------------------------------------------------------------------------------------
  logic [SLOT_W-1:0] done_granted;
  assign done_granted = acq_q ? SLOT_W'(slot_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if ((in_fire && req_err) || done) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && req_err) begin
      m_data_q <= {COUNT_W'(busy_total_q), COUNT_W'(idle_total_q), SLOT_W'(0), err_status};
    end else if (done) begin
      m_data_q <= {COUNT_W'(busy_total_q), COUNT_W'(idle_total_q), done_granted, STAT_OK};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // ---------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------
  a_counts_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (POOL_W + 1)'(idle_total_q) + (POOL_W + 1)'(busy_total_q) == (POOL_W + 1)'(pool_q))
    else $error("idle and busy counts do not add up to the pool size");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_empty_q == (idle_total_q == '0))
    else $error("idle empty flag disagrees with idle count");

  a_busy_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(busy_mark_q) == int'(busy_total_q))
    else $error("busy marks disagree with busy count");

  a_no_accept_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |-> !s_axis_tready)
    else $error("request accepted during clearing pass");

endmodule

/* hw/rtl/spa_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module spa_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for slot_pool_allocator_unit: requests stream in, responses are
// checked field by field against an in-bench model of the idle and busy slot rings.
// Depends on spa_pkg and the allocator RTL.
module tb_top;
  import spa_pkg::*;

  localparam int unsigned NSLOT       = MAX_SLOTS_DEF;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 155;

  // request and response layouts, last member in the lowest bits
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    op_e               op;
  } request_t;

  typedef struct packed {
    logic [COUNT_W-1:0] busy_cnt;
    logic [COUNT_W-1:0] idle_cnt;
    logic [SLOT_W-1:0]  granted;
    status_e            status;
  } response_t;

  // both rings with per-slot links and busy marks
  typedef struct packed {
    logic [POOL_W-1:0]            size;
    logic [NSLOT-1:0][SLOT_W-1:0] nxt;
    logic [NSLOT-1:0][SLOT_W-1:0] prv;
    logic [NSLOT-1:0]             busy;
    logic [SLOT_W-1:0]            idle_head;
    logic [SLOT_W-1:0]            busy_head;
    logic                         idle_empty;
    logic                         busy_empty;
    logic [COUNT_W-1:0]           idle_total;
    logic [COUNT_W-1:0]           busy_total;
  } pool_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [POOL_W-1:0]      cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  request_t    pending_req[$];
  response_t   expected_resp[$];
  pool_t       pool_ref;
  pool_t       pool_plan;
  request_t    offered;
  response_t   seen;
  response_t   want;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_count      = 0;
  int unsigned hold_cnt       = 0;
  logic        hold_trig      = 1'b0;

  slot_pool_allocator_unit #(
    .MAX_SLOTS(NSLOT)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // all slots idle on one ring in index order; size clamped to 1..NSLOT
  function automatic pool_t pool_rebuild(logic [POOL_W-1:0] raw);
    pool_t       p;
    int unsigned sz;
    sz = raw;
    if (sz < 1) sz = 1;
    if (sz > NSLOT) sz = NSLOT;
    p = '0;
    p.size = POOL_W'(sz);
    for (int unsigned i = 0; i < NSLOT; i++) begin
      if (i < sz) begin
        p.nxt[i] = SLOT_W'((i + 1) % sz);
        p.prv[i] = SLOT_W'((i + sz - 1) % sz);
      end else begin
        p.nxt[i] = SLOT_W'(i);
        p.prv[i] = SLOT_W'(i);
      end
    end
    p.busy_empty = 1'b1;
    p.idle_total = COUNT_W'(sz);
    return p;
  endfunction

  // take s off its ring; returns 1 when that ring is now empty
  function automatic logic ring_unlink(inout pool_t p, input logic [SLOT_W-1:0] s,
                                       output logic [SLOT_W-1:0] succ);
    logic [SLOT_W-1:0] pp;
    logic [SLOT_W-1:0] nn;
    pp = p.prv[s];
    nn = p.nxt[s];
    succ = '0;
    if (nn == s) return 1'b1;
    p.nxt[pp] = nn;
    p.prv[nn] = pp;
    succ = nn;
    return 1'b0;
  endfunction

  // put s just ahead of head h, or alone on an empty ring
  function automatic void ring_insert(inout pool_t p, input logic [SLOT_W-1:0] s,
                                      input logic [SLOT_W-1:0] h, input logic empty);
    logic [SLOT_W-1:0] pp;
    if (empty) begin
      p.prv[s] = s;
      p.nxt[s] = s;
    end else begin
      pp = p.prv[h];
      p.prv[s] = pp;
      p.nxt[s] = h;
      p.nxt[pp] = s;
      p.prv[h] = s;
    end
  endfunction

  // one acquire or release against the rings
  function automatic response_t pool_step(inout pool_t p, input request_t r);
    response_t         rsp;
    logic [SLOT_W-1:0] s;
    logic [SLOT_W-1:0] succ;
    rsp = '0;
    rsp.status = STAT_OK;
    if (r.op == OP_ACQUIRE) begin
      if (p.idle_empty) begin
        rsp.status = STAT_NO_IDLE;
      end else begin
        s = p.idle_head;
        if (ring_unlink(p, s, succ)) p.idle_empty = 1'b1;
        else p.idle_head = succ;
        ring_insert(p, s, p.busy_head, p.busy_empty);
        p.busy_empty = 1'b0;
        p.busy_head = s;
        p.busy[s] = 1'b1;
        if (p.idle_total > 0) p.idle_total = p.idle_total - 1'b1;
        p.busy_total = p.busy_total + 1'b1;
        rsp.granted = s;
      end
    end else begin
      if (p.busy_empty) begin
        rsp.status = STAT_BUSY_EMPTY;
      end else if ({1'b0, r.slot} >= p.size || !p.busy[r.slot]) begin
        rsp.status = STAT_BAD_SLOT;
      end else begin
        s = r.slot;
        if (ring_unlink(p, s, succ)) p.busy_empty = 1'b1;
        else p.busy_head = succ;
        ring_insert(p, s, p.idle_head, p.idle_empty);
        p.idle_empty = 1'b0;
        p.idle_head = s;
        p.busy[s] = 1'b0;
        p.idle_total = p.idle_total + 1'b1;
        if (p.busy_total > 0) p.busy_total = p.busy_total - 1'b1;
      end
    end
    rsp.idle_cnt = p.idle_total;
    rsp.busy_cnt = p.busy_total;
    return rsp;
  endfunction

  // request driver: predicts on accept, then offers the next pending request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_resp.push_back(pool_step(pool_ref, offered));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending_req.pop_front();
          s_axis_tdata  <= IN_TDATA_W'(offered);
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_trig) hold_cnt <= HOLD_CYCLES;
    else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  // response ready with random stalls
  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // response monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = response_t'(m_axis_tdata);
      if (expected_resp.size() == 0) begin
        $error("response with none expected: tdata %h", m_axis_tdata);
        err_count++;
      end else begin
        want = expected_resp.pop_front();
        if (seen.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, seen.status);
          err_count++;
        end
        if (seen.granted !== want.granted) begin
          $error("granted_slot expected %0d got %0d", want.granted, seen.granted);
          err_count++;
        end
        if (seen.idle_cnt !== want.idle_cnt) begin
          $error("idle_count expected %0d got %0d", want.idle_cnt, seen.idle_cnt);
          err_count++;
        end
        if (seen.busy_cnt !== want.busy_cnt) begin
          $error("busy_count expected %0d got %0d", want.busy_cnt, seen.busy_cnt);
          err_count++;
        end
      end
    end
  end

  // queue one request and advance the planning copy of the rings
  task automatic queue_req(input op_e op, input logic [SLOT_W-1:0] slot);
    request_t r;
    r.op = op;
    r.slot = slot;
    void'(pool_step(pool_plan, r));
    pending_req.push_back(r);
  endtask

  // mostly legal traffic with a varying acquire bias, plus some noise
  task automatic queue_random(input int unsigned n);
    int unsigned acq_pct;
    int unsigned start;
    int unsigned idx;
    logic        found;
    acq_pct = 50;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0) acq_pct = $urandom_range(80, 20);
      if ($urandom_range(99) < 8) begin
        queue_req(op_e'($urandom_range(1)), SLOT_W'($urandom_range(NSLOT - 1)));
      end else if ($urandom_range(99) < acq_pct || pool_plan.busy_total == 0) begin
        queue_req(OP_ACQUIRE, SLOT_W'($urandom_range(NSLOT - 1)));
      end else begin
        start = $urandom_range(pool_plan.size - 1);
        found = 1'b0;
        idx = 0;
        for (int unsigned k = 0; k < NSLOT; k++) begin
          if (!found && pool_plan.busy[(start + k) % pool_plan.size]) begin
            idx = (start + k) % pool_plan.size;
            found = 1'b1;
          end
        end
        queue_req(OP_RELEASE, SLOT_W'(idx));
      end
    end
  endtask

  // wait until every request is accepted and answered
  task automatic drain();
    while (pending_req.size() != 0 || s_axis_tvalid || expected_resp.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // pool size write while the block is quiet
  task automatic write_pool_size(input logic [POOL_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    pool_ref  = pool_rebuild(value);
    pool_plan = pool_rebuild(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // idle modes: none, sender idle, receiver stall, both light
  task automatic set_idle_mode(input int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
      default: begin send_idle_pct = 11; recv_stall_pct = 11; end
    endcase
  endtask

  // stimulus sequence and final verdict
  initial begin
    logic [POOL_W-1:0] sizes[8];
    sizes = '{5'd31, 5'd2, 5'd16, 5'd5, 5'd1, 5'd17, 5'd3, 5'd0};
    sizes[6] = POOL_W'($urandom_range(31, 1));
    pool_ref  = pool_rebuild(POOL_W'(NSLOT));
    pool_plan = pool_rebuild(POOL_W'(NSLOT));
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full pool after reset: empty busy ring, bad release, middle, head and last unlink
    queue_req(OP_RELEASE, 4'd3);
    queue_req(OP_ACQUIRE, 4'd15);
    queue_req(OP_ACQUIRE, 4'd0);
    queue_req(OP_ACQUIRE, 4'd7);
    queue_req(OP_RELEASE, 4'd15);
    queue_req(OP_RELEASE, 4'd1);
    queue_req(OP_RELEASE, 4'd2);
    queue_req(OP_RELEASE, 4'd0);
    queue_req(OP_ACQUIRE, 4'd0);
    queue_req(OP_RELEASE, 4'd0);
    drain();

    // zero written: pool of one, no idle slot and out-of-range releases
    write_pool_size(5'd0);
    queue_req(OP_ACQUIRE, 4'd9);
    queue_req(OP_ACQUIRE, 4'd0);
    queue_req(OP_RELEASE, 4'd1);
    queue_req(OP_RELEASE, 4'd15);
    queue_req(OP_RELEASE, 4'd0);
    queue_req(OP_RELEASE, 4'd0);
    queue_req(OP_ACQUIRE, 4'd5);
    drain();

    // random phases over several pool sizes and idle modes
    for (int unsigned ph = 0; ph < 8; ph++) begin
      write_pool_size(sizes[ph]);
      set_idle_mode(ph % 4);
      if (ph == 4) begin
        // hold the response side while requests keep coming
        @(posedge clk_i);
        hold_trig <= 1'b1;
        @(posedge clk_i);
        hold_trig <= 1'b0;
      end
      if (ph == 2) begin
        // fill the full pool, then drain it
        for (int unsigned k = 0; k < NSLOT + 1; k++) queue_req(OP_ACQUIRE, 4'hF);
        for (int unsigned k = 0; k < NSLOT + 1; k++) queue_req(OP_RELEASE, SLOT_W'(k));
      end
      queue_random(PHASE_ITEMS);
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(2_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/spa_pkg.sv
hw/rtl/spa_ram.sv
hw/rtl/slot_pool_allocator_unit.sv
bench/tb_top.sv
